/* rtl/ca_rcs_pkg.sv */
// Shared types and constants for the rule-cycling cellular automaton step.
package ca_rcs_pkg;

  localparam int unsigned CELL_COUNT = 64;
  localparam int unsigned RULE_COUNT = 5;
  localparam int unsigned RULE_W     = 16;
  localparam int unsigned RIDX_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned NEIGH_W    = 4;

  typedef logic [RULE_W-1:0]     rule_word_t;
  typedef logic [RIDX_W-1:0]     rule_idx_t;
  typedef logic [CELL_COUNT-1:0] cells_t;

  // request codes carried in req_type
  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_code_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RULE_WORD_0 = 3'd0,
    CFG_RULE_WORD_1 = 3'd1,
    CFG_RULE_WORD_2 = 3'd2,
    CFG_RULE_WORD_3 = 3'd3,
    CFG_RULE_WORD_4 = 3'd4
  } cfg_idx_t;

  localparam rule_idx_t RULE_IDX_FIRST = rule_idx_t'(0);
  localparam rule_idx_t RULE_IDX_LAST  = rule_idx_t'(RULE_COUNT - 1);

  localparam rule_word_t RULE_RESET [RULE_COUNT] = '{
    16'd39318, 16'd42390, 16'd43350, 16'd51510, 16'd57630
  };

  typedef struct packed {
    logic   req_type;
    cells_t seed_value;
  } req_t;

  typedef struct packed {
    cells_t    cells_out;
    rule_idx_t rule_index_out;
  } rsp_t;

endpackage

/* rtl/cellular_automaton_rule_cycling_step.sv */
// Rule-cycling 64-cell ring automaton: one generation or load per item.
// Output: each accepted item's result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the 64 table lookups
//   and the rule index update sit in one logic level between the cell register and result register.
// Reset (synchronous, active high): cells and rule index clear to zero, the
//   five rule words take their default tables, and the output register empties.
module cellular_automaton_rule_cycling_step (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ca_rcs_pkg::req_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ca_rcs_pkg::rsp_t                      out_data,
  input  logic                                  cfg_we,
  input  logic [ca_rcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ca_rcs_pkg::RULE_W-1:0]         cfg_data
);

  ca_rcs_pkg::rule_word_t rule_words [ca_rcs_pkg::RULE_COUNT];
  ca_rcs_pkg::cells_t     cells;
  ca_rcs_pkg::cells_t     cells_next;
  ca_rcs_pkg::cells_t     gen_next;
  ca_rcs_pkg::rule_idx_t  rule_index;
  ca_rcs_pkg::rule_idx_t  rule_index_next;
  ca_rcs_pkg::rule_idx_t  step_index;
  ca_rcs_pkg::rule_word_t cur_rule;
  logic                   in_accept;

  // take an item whenever the result slot is empty or drains this cycle
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign cur_rule = rule_words[step_index];

  // look up every new cell from its four-cell neighborhood
  for (genvar i = 0; i < ca_rcs_pkg::CELL_COUNT; i++) begin : g_cell
    localparam int unsigned IM1 = (i + ca_rcs_pkg::CELL_COUNT - 1) % ca_rcs_pkg::CELL_COUNT;
    localparam int unsigned IP1 = (i + 1) % ca_rcs_pkg::CELL_COUNT;
    localparam int unsigned IP2 = (i + 2) % ca_rcs_pkg::CELL_COUNT;
    logic [ca_rcs_pkg::NEIGH_W-1:0] code;
    assign code        = {cells[IP2], cells[IP1], cells[i], cells[IM1]};
    assign gen_next[i] = cur_rule[code];
  end

  // move the rule index up when the old cell 0 is set, else down, wrapping over five rules
  always_comb begin
    step_index = (rule_index > ca_rcs_pkg::RULE_IDX_LAST) ?
                 ca_rcs_pkg::RULE_IDX_FIRST : rule_index;
    if (cells[0]) begin
      rule_index_next = (step_index == ca_rcs_pkg::RULE_IDX_LAST) ?
                        ca_rcs_pkg::RULE_IDX_FIRST :
                        ca_rcs_pkg::rule_idx_t'(step_index + 1'b1);
    end else begin
      rule_index_next = (step_index == ca_rcs_pkg::RULE_IDX_FIRST) ?
                        ca_rcs_pkg::RULE_IDX_LAST :
                        ca_rcs_pkg::rule_idx_t'(step_index - 1'b1);
    end
  end

  // pick the new cells by request type
  always_comb begin
    unique case (ca_rcs_pkg::req_code_t'(in_data.req_type))
      ca_rcs_pkg::REQ_LOAD: cells_next = in_data.seed_value;
      ca_rcs_pkg::REQ_STEP: cells_next = gen_next;
      default:              cells_next = in_data.seed_value;
    endcase
  end

  // hold the rule words, written from the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ca_rcs_pkg::RULE_COUNT; k++) begin
        rule_words[k] <= ca_rcs_pkg::RULE_RESET[k];
      end
    end else if (cfg_we) begin
      unique case (ca_rcs_pkg::cfg_idx_t'(cfg_index))
        ca_rcs_pkg::CFG_RULE_WORD_0: rule_words[0] <= cfg_data;
        ca_rcs_pkg::CFG_RULE_WORD_1: rule_words[1] <= cfg_data;
        ca_rcs_pkg::CFG_RULE_WORD_2: rule_words[2] <= cfg_data;
        ca_rcs_pkg::CFG_RULE_WORD_3: rule_words[3] <= cfg_data;
        ca_rcs_pkg::CFG_RULE_WORD_4: rule_words[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance automaton state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      cells      <= '0;
      rule_index <= ca_rcs_pkg::RULE_IDX_FIRST;
    end else if (in_accept) begin
      cells <= cells_next;
      if (in_data.req_type == ca_rcs_pkg::REQ_STEP) begin
        rule_index <= rule_index_next;
      end
    end
  end

  // result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data.cells_out      <= cells_next;
      out_data.rule_index_out <= (in_data.req_type == ca_rcs_pkg::REQ_STEP) ?
                                 rule_index_next : rule_index;
    end
  end

`ifndef SYNTHESIS
  a_rule_index_range: assert property (@(posedge clk) disable iff (rst)
    rule_index <= ca_rcs_pkg::RULE_IDX_LAST)
    else $error("rule index out of range");

  a_step_moves_index: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.req_type == ca_rcs_pkg::REQ_STEP
    |=> rule_index != $past(rule_index))
    else $error("step did not move rule index");

  a_load_keeps_index: assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.req_type == ca_rcs_pkg::REQ_LOAD
    |=> rule_index == $past(rule_index) && cells == $past(in_data.seed_value))
    else $error("load changed rule index or missed seed");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid && out_data.cells_out == cells
                 && out_data.rule_index_out == rule_index)
    else $error("result register disagrees with state");
`endif

endmodule

/* tb/sv/tb_cellular_automaton_rule_cycling_step.sv */
// Testbench for the rule-cycling 64-cell ring automaton step block.
module tb_cellular_automaton_rule_cycling_step;
  timeunit 1ns;
  timeprecision 1ps;

  import ca_rcs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 60;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  req_t       in_data;
  logic       out_valid;
  logic       out_ready;
  rsp_t       out_data;
  logic       cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RULE_W-1:0]    cfg_data;

  // predictor state: ring, rule pointer and rule tables
  cells_t      ring_model;
  rule_idx_t   ridx_model;
  rule_word_t  rules_model [RULE_COUNT];

  rsp_t        gen_expect_q [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  // knobs for the sender and the receiver
  int unsigned tx_max_gap = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_len = 0;

  cellular_automaton_rule_cycling_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic req_t mk_req(input req_code_t code, input cells_t seed);
    req_t r;
    r.req_type   = code;
    r.seed_value = seed;
    return r;
  endfunction

  function automatic cells_t rand_cells();
    return {$urandom, $urandom};
  endfunction

  // Draw five random rule tables packed as word k at bits [16k +: 16].
  function automatic logic [RULE_COUNT*RULE_W-1:0] rand_rules();
    logic [3*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[RULE_COUNT*RULE_W-1:0];
  endfunction

  // Offer one item, hold it until accepted, then predict its result.
  task automatic send_req(input req_t r);
    rsp_t      want;
    cells_t    nxt;
    logic [NEIGH_W-1:0] code;
    int unsigned i;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    if (r.req_type == REQ_LOAD) begin
      ring_model = r.seed_value;
    end else begin
      // neighborhood code: bit0 = i-1, bit1 = i, bit2 = i+1, bit3 = i+2
      for (i = 0; i < CELL_COUNT; i++) begin
        code = {ring_model[(i + 2) % CELL_COUNT], ring_model[(i + 1) % CELL_COUNT],
                ring_model[i], ring_model[(i + CELL_COUNT - 1) % CELL_COUNT]};
        nxt[i] = rules_model[ridx_model][code];
      end
      // move the rule pointer on the old cell 0
      if (ring_model[0]) begin
        ridx_model = (ridx_model == RULE_IDX_LAST) ? RULE_IDX_FIRST
                                                   : rule_idx_t'(ridx_model + 1);
      end else begin
        ridx_model = (ridx_model == RULE_IDX_FIRST) ? RULE_IDX_LAST
                                                    : rule_idx_t'(ridx_model - 1);
      end
      ring_model = nxt;
    end
    want.cells_out      = ring_model;
    want.rule_index_out = ridx_model;
    gen_expect_q.push_back(want);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (gen_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all five rule tables; word k sits at bits [16k +: 16].
  task automatic program_rules(input logic [RULE_COUNT*RULE_W-1:0] words);
    int unsigned k;
    for (k = 0; k < RULE_COUNT; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(k);
      cfg_data  <= words[k*RULE_W +: RULE_W];
      @(posedge clk);
      rules_model[k] = words[k*RULE_W +: RULE_W];
    end
    cfg_we <= 1'b0;
  endtask

  // Send n items in bursts; each is a load with load_pct percent chance, the rest advance.
  task automatic send_random(input int unsigned n, input int unsigned load_pct);
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    cells_t      seed;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(16, 1);
      while (burst != 0 && sent < n) begin
        pick = $urandom_range(7);
        case (pick)
          0:       seed = cells_t'(1) << $urandom_range(CELL_COUNT - 1);
          1:       seed = ~(cells_t'(1) << $urandom_range(CELL_COUNT - 1));
          2:       seed = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
          default: seed = rand_cells();
        endcase
        send_req(mk_req(($urandom_range(99) < load_pct) ? REQ_LOAD : REQ_STEP, seed));
        sent++;
        burst--;
      end
      gap = (tx_max_gap == 0) ? 0 : $urandom_range(tx_max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Ring extremes, wrap at both ends, seed ignored on advance, default tables.
  task automatic test_directed();
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, '1));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, '0));
    send_req(mk_req(REQ_STEP, '1));
    send_req(mk_req(REQ_STEP, 64'h0123_4567_89ab_cdef));
    send_req(mk_req(REQ_LOAD, 64'h0000_0000_0000_0001));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, 64'h8000_0000_0000_0000));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, 64'hc000_0000_0000_0003));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, 64'haaaa_aaaa_aaaa_aaaa));
    send_req(mk_req(REQ_STEP, '0));
    send_req(mk_req(REQ_LOAD, 64'h5555_5555_5555_5555));
    send_req(mk_req(REQ_STEP, rand_cells()));
    send_req(mk_req(REQ_LOAD, rand_cells()));
    repeat (5) send_req(mk_req(REQ_STEP, rand_cells()));
    drain();
  endtask

  // Run a few generations under extreme and mixed rule tables.
  task automatic test_rule_extremes();
    int unsigned phase;
    logic [RULE_COUNT*RULE_W-1:0] words;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       words = '0;
        1:       words = '1;
        2:       words = {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
        3:       words = {16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff};
        4:       words = {16'h00ff, 16'hf0f0, 16'hcccc, 16'haaaa, 16'hff00};
        default: words = rand_rules();
      endcase
      program_rules(words);
      send_req(mk_req(REQ_LOAD, rand_cells()));
      send_random(24, 10);
      drain();
    end
  endtask

  // Hold the receiver off while items keep coming, then pause for a full drain.
  task automatic test_backpressure();
    rx_stall_pct = 0;
    tx_max_gap   = 0;
    rx_hold_len <= LONG_HOLD;
    send_random(40, 20);
    drain();
    rx_stall_pct = 50;
    tx_max_gap   = 2;
    rx_hold_len <= LONG_HOLD / 2;
    send_random(30, 20);
    drain();
  endtask

  // Long random runs over several table settings and idling mixes.
  task automatic test_random_mix();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          rx_stall_pct = 0;
          tx_max_gap   = 0;
        end
        1: begin
          program_rules(rand_rules());
          rx_stall_pct = 30;
          tx_max_gap   = 3;
        end
        2: begin
          program_rules(rand_rules());
          rx_stall_pct = 70;
          tx_max_gap   = 6;
        end
        default: begin
          program_rules({RULE_RESET[4], RULE_RESET[3], RULE_RESET[2],
                         RULE_RESET[1], RULE_RESET[0]});
          rx_stall_pct = 20;
          tx_max_gap   = 2;
        end
      endcase
      send_random(250, 15);
      drain();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin : rx_pattern
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len != 0) begin
        hold_left = rx_hold_len;
        rx_hold_len <= 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (gen_expect_q.size() == 0) begin
        $display("%0t MISMATCH: result with none pending, cells %h index %0d",
                 $time, out_data.cells_out, out_data.rule_index_out);
        err_cnt++;
      end else begin
        want = gen_expect_q.pop_front();
        if (out_data.cells_out !== want.cells_out) begin
          $display("%0t MISMATCH cells_out: expected %h actual %h",
                   $time, want.cells_out, out_data.cells_out);
          err_cnt++;
        end
        if (out_data.rule_index_out !== want.rule_index_out) begin
          $display("%0t MISMATCH rule_index_out: expected %0d actual %0d",
                   $time, want.rule_index_out, out_data.rule_index_out);
          err_cnt++;
        end
      end
    end
  end

  // Bound the run.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : main_seq
    int unsigned k;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_RULE_WORD_0;
    cfg_data  <= '0;
    ring_model = '0;
    ridx_model = RULE_IDX_FIRST;
    for (k = 0; k < RULE_COUNT; k++) rules_model[k] = RULE_RESET[k];
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_rule_extremes();
    test_backpressure();
    test_random_mix();

    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ca_rcs_pkg.sv
rtl/cellular_automaton_rule_cycling_step.sv
tb/sv/tb_cellular_automaton_rule_cycling_step.sv
